@@ rtl/core/staggered_relay_restart_sequencer_top_defines.svh @@
// Assertion macros shared by the relay restart sequencer checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef STAGGERED_RELAY_RESTART_SEQUENCER_TOP_DEFINES_SVH
`define STAGGERED_RELAY_RESTART_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define SRRS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define SRRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/srrs_pkg.sv @@
// Shared constants, payload types and helper functions of the relay restart sequencer.
// Used by every module of the block; depends on nothing else.
package srrs_pkg;

  localparam int PLUG_COUNT = 10;
  localparam int TIMER_BITS = 20;
  localparam int CFG_BITS   = 20;
  localparam int MASK_BITS  = 11;
  localparam int PLUG_BITS  = 4;
  localparam int SLOT_BITS  = $clog2(PLUG_COUNT + 1);
  localparam int CMP_BITS   = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_WAIT = 3'd1;
  localparam logic [2:0] PH_ENER = 3'd2;
  localparam logic [2:0] PH_MON  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_ABORT = 2'd2;
  localparam logic [1:0] OP_BLOCK = 2'd3;

  localparam logic [1:0] REG_WAIT    = 2'd0;
  localparam logic [1:0] REG_STAGGER = 2'd1;
  localparam logic [1:0] REG_MONITOR = 2'd2;

  localparam logic [CFG_BITS-1:0] WAIT_RESET    = CFG_BITS'(30000);
  localparam logic [CFG_BITS-1:0] STAGGER_RESET = CFG_BITS'(5000);
  localparam logic [CFG_BITS-1:0] MONITOR_RESET = CFG_BITS'(10000);

  typedef struct packed {
    logic [1:0]           op;
    logic [MASK_BITS-1:0] blocked_in;
  } req_t;

  typedef struct packed {
    logic [2:0]           phase;
    logic                 active;
    logic                 complete;
    logic [3:0]           released_count;
    logic [MASK_BITS-1:0] energized_mask;
  } rsp_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] wait_ticks;
    logic [CFG_BITS-1:0] stagger_ticks;
    logic [CFG_BITS-1:0] monitor_ticks;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic pt_clr;
    logic pt_inc;
    logic st_clr;
    logic st_inc;
    logic slot_clr;
    logic slot_adv;
    logic blk_clr;
    logic blk_load;
    logic span_part;
    logic span_all;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic wait_hit;
    logic stagger_hit;
    logic monitor_hit;
    logic slots_done;
  } stat_t;

  // Plug released by a given order slot; slots past the fixed list run in plug order.
  function automatic logic [PLUG_BITS-1:0] release_plug(input logic [SLOT_BITS-1:0] slot);
    case (slot)
      SLOT_BITS'(0): release_plug = PLUG_BITS'(4);
      SLOT_BITS'(1): release_plug = PLUG_BITS'(5);
      SLOT_BITS'(2): release_plug = PLUG_BITS'(1);
      SLOT_BITS'(3): release_plug = PLUG_BITS'(6);
      SLOT_BITS'(4): release_plug = PLUG_BITS'(2);
      SLOT_BITS'(5): release_plug = PLUG_BITS'(3);
      default:       release_plug = PLUG_BITS'(slot + 1'b1);
    endcase
  endfunction

  // Plugs beyond the mask width can never be blocked.
  function automatic logic plug_blocked(input logic [PLUG_BITS-1:0] plug,
                                        input logic [MASK_BITS-1:0] blocked);
    plug_blocked = (plug < PLUG_BITS'(MASK_BITS)) ? blocked[plug] : 1'b0;
  endfunction

endpackage

@@ rtl/core/srrs_cfg.sv @@
// Configuration register file of the relay restart sequencer behind an APB-style port.
// Depends on srrs_pkg for the register indexes, widths and reset values.
module srrs_cfg import srrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_ticks    <= WAIT_RESET;
      cfg.stagger_ticks <= STAGGER_RESET;
      cfg.monitor_ticks <= MONITOR_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_WAIT:    cfg.wait_ticks    <= pwdata[CFG_BITS-1:0];
        REG_STAGGER: cfg.stagger_ticks <= pwdata[CFG_BITS-1:0];
        REG_MONITOR: cfg.monitor_ticks <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_WAIT:    prdata = DATA_BITS'(cfg.wait_ticks);
      REG_STAGGER: prdata = DATA_BITS'(cfg.stagger_ticks);
      REG_MONITOR: prdata = DATA_BITS'(cfg.monitor_ticks);
      default:     prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/srrs_ctrl.sv @@
// Phase state machine of the relay restart sequencer; issues datapath commands.
// Depends on srrs_pkg for phase and operation codes and the command/status types.
module srrs_ctrl import srrs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [1:0] op,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic [2:0] phase,
  output logic       done_flag
);

  logic [2:0] phase_next;
  logic       done_flag_next;

  always_comb begin
    phase_next     = phase;
    done_flag_next = done_flag;
    cmd            = '0;
    cmd.span_part  = (phase == PH_ENER);
    cmd.span_all   = (phase == PH_MON) || (phase == PH_DONE);
    if (go) begin
      case (op)
        OP_TICK: begin
          case (phase)
            PH_WAIT: begin
              if (stat.wait_hit) begin
                phase_next   = PH_ENER;
                cmd.pt_clr   = 1'b1;
                cmd.st_clr   = 1'b1;
                cmd.slot_clr = 1'b1;
              end else begin
                cmd.pt_inc = 1'b1;
              end
            end
            PH_ENER: begin
              if (stat.slots_done) begin
                phase_next = PH_MON;
                cmd.pt_clr = 1'b1;
              end else if (stat.stagger_hit) begin
                cmd.slot_adv = 1'b1;
                cmd.st_clr   = 1'b1;
              end else begin
                cmd.st_inc = 1'b1;
              end
            end
            PH_MON: begin
              // The timer also advances on the tick that finishes monitoring.
              cmd.pt_inc = 1'b1;
              if (stat.monitor_hit) begin
                phase_next     = PH_DONE;
                done_flag_next = 1'b1;
              end
            end
            default: ;
          endcase
        end
        OP_START: begin
          phase_next     = PH_WAIT;
          done_flag_next = 1'b0;
          cmd.pt_clr     = 1'b1;
          cmd.st_clr     = 1'b1;
          cmd.slot_clr   = 1'b1;
          cmd.blk_clr    = 1'b1;
        end
        OP_ABORT: begin
          phase_next     = PH_IDLE;
          done_flag_next = 1'b0;
          cmd.slot_clr   = 1'b1;
        end
        default: begin
          cmd.blk_load = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      done_flag <= 1'b0;
    end else begin
      phase     <= phase_next;
      done_flag <= done_flag_next;
    end
  end

endmodule

@@ rtl/core/srrs_dp.sv @@
// Datapath of the relay restart sequencer: timers, slot pointer, blocked mask, energized mask.
// Depends on srrs_pkg for widths, the release order and the command/status types.
module srrs_dp import srrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  cfg_t                 cfg,
  input  logic [MASK_BITS-1:0] blocked_in,
  output stat_t                stat,
  output logic [SLOT_BITS-1:0] next_slot,
  output logic [MASK_BITS-1:0] energized_mask
);

  logic [TIMER_BITS-1:0] phase_timer;
  logic [TIMER_BITS-1:0] phase_timer_next;
  logic [TIMER_BITS-1:0] slot_timer;
  logic [TIMER_BITS-1:0] slot_timer_next;
  logic [SLOT_BITS-1:0]  next_slot_next;
  logic [MASK_BITS-1:0]  blocked_plugs;
  logic [MASK_BITS-1:0]  blocked_plugs_next;
  logic [TIMER_BITS-1:0] pt_inc;
  logic [TIMER_BITS-1:0] st_inc;
  logic [SLOT_BITS-1:0]  skip_slot;
  logic [SLOT_BITS-1:0]  span;

  assign pt_inc = (phase_timer == TIMER_MAX) ? phase_timer : phase_timer + 1'b1;
  assign st_inc = (slot_timer == TIMER_MAX) ? slot_timer : slot_timer + 1'b1;

  assign stat.wait_hit    = CMP_BITS'(pt_inc) >= CMP_BITS'(cfg.wait_ticks);
  assign stat.monitor_hit = CMP_BITS'(pt_inc) >= CMP_BITS'(cfg.monitor_ticks);
  assign stat.stagger_hit = CMP_BITS'(st_inc) >= CMP_BITS'(cfg.stagger_ticks);
  assign stat.slots_done  = next_slot >= SLOT_BITS'(PLUG_COUNT);

  // The pointer moves past the current slot and then past every blocked slot after it.
  always_comb begin
    skip_slot = SLOT_BITS'(PLUG_COUNT);
    for (int i = PLUG_COUNT - 1; i >= 0; i--) begin
      if (SLOT_BITS'(i) > next_slot &&
          !plug_blocked(release_plug(SLOT_BITS'(i)), blocked_plugs)) begin
        skip_slot = SLOT_BITS'(i);
      end
    end
  end

  always_comb begin
    phase_timer_next   = phase_timer;
    slot_timer_next    = slot_timer;
    next_slot_next     = next_slot;
    blocked_plugs_next = blocked_plugs;
    if (cmd.pt_clr) begin
      phase_timer_next = '0;
    end else if (cmd.pt_inc) begin
      phase_timer_next = pt_inc;
    end
    if (cmd.st_clr) begin
      slot_timer_next = '0;
    end else if (cmd.st_inc) begin
      slot_timer_next = st_inc;
    end
    if (cmd.slot_clr) begin
      next_slot_next = '0;
    end else if (cmd.slot_adv) begin
      next_slot_next = skip_slot;
    end
    if (cmd.blk_clr) begin
      blocked_plugs_next = '0;
    end else if (cmd.blk_load) begin
      blocked_plugs_next = blocked_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_timer   <= '0;
      slot_timer    <= '0;
      next_slot     <= '0;
      blocked_plugs <= '0;
    end else begin
      phase_timer   <= phase_timer_next;
      slot_timer    <= slot_timer_next;
      next_slot     <= next_slot_next;
      blocked_plugs <= blocked_plugs_next;
    end
  end

  always_comb begin
    if (cmd.span_all) begin
      span = SLOT_BITS'(PLUG_COUNT);
    end else if (cmd.span_part) begin
      span = next_slot;
    end else begin
      span = '0;
    end
  end

  always_comb begin
    energized_mask = '0;
    for (int i = 0; i < PLUG_COUNT; i++) begin
      if (SLOT_BITS'(i) < span &&
          release_plug(SLOT_BITS'(i)) < PLUG_BITS'(MASK_BITS) &&
          !plug_blocked(release_plug(SLOT_BITS'(i)), blocked_plugs)) begin
        energized_mask[release_plug(SLOT_BITS'(i))] = 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/staggered_relay_restart_sequencer_top.sv @@
// Staggered relay restart sequencer: one request item in, one status item out per request.
// Each request is handled in the cycle it is accepted; the phase, timer and slot registers
// then hold the status until it is transferred, so a request is taken every cycle unless a
// status transfer is stalled. Status fields are formed from those registers, which need no
// clearing pass after reset. Depends on srrs_pkg, srrs_cfg, srrs_ctrl and srrs_dp.
module staggered_relay_restart_sequencer_top import srrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t                 cfg;
  cmd_t                 cmd;
  stat_t                stat;
  logic                 go;
  logic [2:0]           phase;
  logic                 done_flag;
  logic [SLOT_BITS-1:0] next_slot;
  logic [MASK_BITS-1:0] energized_mask;

  // A new request would overwrite the state that a stalled status still shows.
  assign req_stall = rsp_valid && rsp_stall;
  assign go        = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  srrs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .op        (req.op),
    .stat      (stat),
    .cmd       (cmd),
    .phase     (phase),
    .done_flag (done_flag)
  );

  srrs_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .blocked_in     (req.blocked_in),
    .stat           (stat),
    .next_slot      (next_slot),
    .energized_mask (energized_mask)
  );

  assign rsp.phase          = phase;
  assign rsp.active         = (phase == PH_WAIT) || (phase == PH_ENER) || (phase == PH_MON);
  assign rsp.complete       = done_flag;
  assign rsp.released_count = 4'(next_slot);
  assign rsp.energized_mask = energized_mask;

endmodule

@@ rtl/core/srrs_checker.sv @@
// Port-level checks of the relay restart sequencer, bound to the top level.
// Depends on srrs_pkg and the assertion macros in the block's defines header.
`include "staggered_relay_restart_sequencer_top_defines.svh"

module srrs_checker import srrs_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  logic accept;
  logic held;
  logic abort_go;
  logic start_go;
  logic idle_clear;
  logic wait_clear;

  assign accept     = req_valid && !req_stall;
  assign held       = rsp_valid && rsp_stall;
  assign abort_go   = accept && (req.op == OP_ABORT);
  assign start_go   = accept && (req.op == OP_START);
  assign idle_clear = (rsp.phase == PH_IDLE) && (rsp.released_count == 4'd0) && !rsp.complete;
  assign wait_clear = (rsp.phase == PH_WAIT) && (rsp.energized_mask == '0) && rsp.active;

  `SRRS_ASSERT_SAME(a_stall_pending, req_stall, held, "request stalled without a pending status")
  `SRRS_ASSERT_NEXT(a_accept_status, accept, rsp_valid, "accepted request produced no status")
  `SRRS_ASSERT_NEXT(a_abort_idle, abort_go, idle_clear, "abort did not return to idle")
  `SRRS_ASSERT_NEXT(a_start_wait, start_go, wait_clear, "start did not enter waiting")
  `SRRS_ASSERT_NEXT(a_status_holds, held, rsp_valid && $stable(rsp), "stalled status changed")

endmodule

bind staggered_relay_restart_sequencer_top srrs_checker u_srrs_checker (.*);

@@ tb/tb_staggered_relay_restart_sequencer_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the staggered relay restart sequencer: a directed table,
// then randomized command phases under random stalls, checked against an in-bench predictor.
// Depends on srrs_pkg and staggered_relay_restart_sequencer_top.
module tb_staggered_relay_restart_sequencer_top;
  import srrs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 60;
  localparam int SPLIT_ROW = 7;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [CFG_BITS-1:0] CFG_MAX = '1;
  localparam logic [MASK_BITS-1:0] NO_PLUGS = '0;

  localparam rsp_t IDLE_STATUS = '{PH_IDLE, 1'b0, 1'b0, 4'd0, NO_PLUGS};
  localparam rsp_t WAIT_STATUS = '{PH_WAIT, 1'b1, 1'b0, 4'd0, NO_PLUGS};
  localparam rsp_t ENER_STATUS = '{PH_ENER, 1'b1, 1'b0, 4'd0, NO_PLUGS};

  typedef struct {
    req_t item;
    bit   typed;
    rsp_t status;
  } step_row_t;

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  req_t                 req;
  logic                 rsp_valid;
  logic                 rsp_stall;
  rsp_t                 rsp;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  // Predictor copy of the configuration and the sequencer state.
  logic [CFG_BITS-1:0]   wait_cfg;
  logic [CFG_BITS-1:0]   stagger_cfg;
  logic [CFG_BITS-1:0]   monitor_cfg;
  logic [2:0]            seq_phase;
  logic [TIMER_BITS-1:0] phase_time;
  logic [TIMER_BITS-1:0] slot_time;
  int                    slot_ptr;
  logic [MASK_BITS-1:0]  blocked_plugs_q;
  bit                    done_q;
  int unsigned           release_order [PLUG_COUNT] = '{4, 5, 1, 6, 2, 3, 7, 8, 9, 10};

  rsp_t expected_status_q[$];
  int   error_count;
  int   cycle_count;
  bit   calm;
  bit   rush;
  bit   hold_out_req;

  staggered_relay_restart_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [TIMER_BITS-1:0] saturating_inc(input logic [TIMER_BITS-1:0] t);
    return (t == TIMER_MAX) ? t : t + 1'b1;
  endfunction

  function automatic logic [MASK_BITS-1:0] energized_plugs();
    int n;
    logic [MASK_BITS-1:0] m;
    m = '0;
    if (seq_phase == PH_ENER) begin
      n = slot_ptr;
    end else if (seq_phase == PH_MON || seq_phase == PH_DONE) begin
      n = PLUG_COUNT;
    end else begin
      n = 0;
    end
    for (int i = 0; i < n; i++) begin
      if (!blocked_plugs_q[release_order[i]]) m[release_order[i]] = 1'b1;
    end
    return m;
  endfunction

  function automatic void tick_sequencer();
    case (seq_phase)
      PH_WAIT: begin
        phase_time = saturating_inc(phase_time);
        if (phase_time >= wait_cfg) begin
          seq_phase = PH_ENER;
          phase_time = '0;
          slot_time = '0;
          slot_ptr = 0;
        end
      end
      PH_ENER: begin
        if (slot_ptr >= PLUG_COUNT) begin
          seq_phase = PH_MON;
          phase_time = '0;
        end else begin
          slot_time = saturating_inc(slot_time);
          if (slot_time >= stagger_cfg) begin
            // The slot just passed is released even if its plug is blocked;
            // only the slots that follow are skipped.
            slot_ptr++;
            while (slot_ptr < PLUG_COUNT && blocked_plugs_q[release_order[slot_ptr]])
              slot_ptr++;
            slot_time = '0;
          end
        end
      end
      PH_MON: begin
        phase_time = saturating_inc(phase_time);
        if (phase_time >= monitor_cfg) begin
          seq_phase = PH_DONE;
          done_q = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic rsp_t step_sequencer(input req_t item);
    rsp_t r;
    case (item.op)
      OP_TICK: tick_sequencer();
      OP_START: begin
        seq_phase = PH_WAIT;
        phase_time = '0;
        slot_time = '0;
        slot_ptr = 0;
        done_q = 1'b0;
        blocked_plugs_q = '0;
      end
      OP_ABORT: begin
        seq_phase = PH_IDLE;
        done_q = 1'b0;
        slot_ptr = 0;
      end
      default: blocked_plugs_q = item.blocked_in;
    endcase
    r.phase = seq_phase;
    r.active = (seq_phase == PH_WAIT || seq_phase == PH_ENER || seq_phase == PH_MON);
    r.complete = done_q;
    r.released_count = 4'(slot_ptr);
    r.energized_mask = energized_plugs();
    return r;
  endfunction

  function automatic step_row_t row(input logic [1:0] op, input logic [MASK_BITS-1:0] blk,
                                    input bit typed, input rsp_t status);
    step_row_t s;
    s.item.op = op;
    s.item.blocked_in = blk;
    s.typed = typed;
    s.status = status;
    return s;
  endfunction

  function automatic req_t random_request(input bit clean);
    req_t item;
    int r;
    r = $urandom_range(0, 99);
    item.blocked_in = MASK_BITS'($urandom);
    if (clean) begin
      item.op = (r < 85) ? OP_TICK : (r < 93) ? OP_BLOCK : (r < 97) ? OP_ABORT : OP_START;
    end else begin
      item.op = (r < 60) ? OP_TICK : (r < 75) ? OP_BLOCK : (r < 88) ? OP_ABORT : OP_START;
    end
    return item;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    error_count++;
    if (error_count <= 30)
      $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(input req_t item, input bit typed, input rsp_t status);
    int gap;
    rsp_t predicted;
    gap = (rush || calm) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    predicted = step_sequencer(item);
    expected_status_q.push_back(typed ? status : predicted);
    @(negedge clk);
  endtask

  // Stops offering and waits until every status transfer has come back.
  task automatic settle();
    req_valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] value);
    logic [DATA_BITS-1:0] data;
    data = $urandom;
    data[CFG_BITS-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BITS'({idx, 2'b00});
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_WAIT:    wait_cfg = value;
      REG_STAGGER: stagger_cfg = value;
      REG_MONITOR: monitor_cfg = value;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [DATA_BITS-1:0] want;
    case (idx)
      REG_WAIT:    want = DATA_BITS'(wait_cfg);
      REG_STAGGER: want = DATA_BITS'(stagger_cfg);
      default:     want = DATA_BITS'(monitor_cfg);
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_BITS'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want) flag_mismatch("register readback", prdata, want);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_config(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] s,
                             input logic [CFG_BITS-1:0] m);
    write_reg(REG_WAIT, w);
    write_reg(REG_STAGGER, s);
    write_reg(REG_MONITOR, m);
    check_reg(REG_WAIT);
    check_reg(REG_STAGGER);
    check_reg(REG_MONITOR);
  endtask

  // Status receiver with its own stall pattern, including one long hold-off.
  initial begin
    int hold;
    rsp_t want;
    rsp_stall = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_out_req) begin
        hold = LONG_HOLD;
        hold_out_req = 1'b0;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 10);
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (rsp_valid !== 1'b1);
      if (expected_status_q.size() == 0) begin
        flag_mismatch("status transfer with nothing expected, phase", rsp.phase, 0);
      end else begin
        want = expected_status_q.pop_front();
        if (rsp.phase !== want.phase) flag_mismatch("phase", rsp.phase, want.phase);
        if (rsp.active !== want.active) flag_mismatch("active", rsp.active, want.active);
        if (rsp.complete !== want.complete)
          flag_mismatch("complete", rsp.complete, want.complete);
        if (rsp.released_count !== want.released_count)
          flag_mismatch("released_count", rsp.released_count, want.released_count);
        if (rsp.energized_mask !== want.energized_mask)
          flag_mismatch("energized_mask", rsp.energized_mask, want.energized_mask);
      end
      @(negedge clk);
    end
  end

  initial begin
    step_row_t rows[$];
    req_t item;
    int n;

    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    rush = 1'b0;
    hold_out_req = 1'b0;
    error_count = 0;
    wait_cfg = WAIT_RESET;
    stagger_cfg = STAGGER_RESET;
    monitor_cfg = MONITOR_RESET;
    seq_phase = PH_IDLE;
    phase_time = '0;
    slot_time = '0;
    slot_ptr = 0;
    blocked_plugs_q = '0;
    done_q = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    check_reg(REG_WAIT);
    check_reg(REG_STAGGER);
    check_reg(REG_MONITOR);

    // Reset configuration: idle handling, start, abort, blocked mask writes.
    rows.push_back(row(OP_TICK, NO_PLUGS, 1'b1, IDLE_STATUS));
    rows.push_back(row(OP_BLOCK, 11'h7FF, 1'b1, IDLE_STATUS));
    rows.push_back(row(OP_ABORT, NO_PLUGS, 1'b1, IDLE_STATUS));
    rows.push_back(row(OP_START, 11'h7FF, 1'b1, WAIT_STATUS));
    rows.push_back(row(OP_TICK, NO_PLUGS, 1'b1, WAIT_STATUS));
    rows.push_back(row(OP_BLOCK, 11'h555, 1'b1, WAIT_STATUS));
    rows.push_back(row(OP_ABORT, NO_PLUGS, 1'b1, IDLE_STATUS));
    // Zero intervals: a full sequence with the first slot's plug blocked,
    // a later blocked slot skipped, and bit zero set.
    rows.push_back(row(OP_START, NO_PLUGS, 1'b1, WAIT_STATUS));
    rows.push_back(row(OP_BLOCK, 11'h013, 1'b1, WAIT_STATUS));
    rows.push_back(row(OP_TICK, NO_PLUGS, 1'b1, ENER_STATUS));
    for (int i = 0; i < 12; i++) rows.push_back(row(OP_TICK, NO_PLUGS, 1'b0, IDLE_STATUS));
    rows.push_back(row(OP_START, 11'h7FF, 1'b1, WAIT_STATUS));
    rows.push_back(row(OP_ABORT, NO_PLUGS, 1'b1, IDLE_STATUS));

    foreach (rows[i]) begin
      if (i == SPLIT_ROW) begin
        settle();
        write_reg(REG_UNUSED, CFG_BITS'($urandom));
        load_config('0, '0, '0);
      end
      send_request(rows[i].item, rows[i].typed, rows[i].status);
    end
    settle();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       load_config(CFG_MAX, CFG_MAX, CFG_MAX);
        1:       load_config('0, CFG_MAX, '0);
        2:       load_config(CFG_BITS'(1), '0, CFG_MAX);
        default: load_config(CFG_BITS'($urandom_range(0, 8)), CFG_BITS'($urandom_range(0, 4)),
                             CFG_BITS'($urandom_range(0, 8)));
      endcase
      calm = (p % 4 == 3);
      n = (p == 0) ? 20 : 55;
      for (int k = 0; k < n; k++) begin
        // Receiver holds off while the sender keeps offering back to back.
        if (p == 4 && k == 10) begin
          hold_out_req = 1'b1;
          rush = 1'b1;
        end
        if (p == 4 && k == 30) rush = 1'b0;
        if (p == 5 && k == 25) settle();
        if (k == 0) begin
          item.op = OP_START;
          item.blocked_in = MASK_BITS'($urandom);
        end else begin
          item = random_request(p % 2 == 0);
        end
        send_request(item, 1'b0, IDLE_STATUS);
      end
      settle();
      calm = 1'b0;
    end

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
